// ----- sv/bdq_pkg.sv -----
// Shared types, constants and command codes of the bounded double-ended queue.
package bdq_pkg;

    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CMD_W      = 4;
    localparam int VAL_W      = 32;
    localparam int POS_W      = 16;
    localparam int RD_W       = 32;
    localparam int COUNT_W    = 9;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [DATA_WIDTH-1:0] t_data;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 4'd0,
        CMD_PUSH_BACK  = 4'd1,
        CMD_POP_FRONT  = 4'd2,
        CMD_POP_BACK   = 4'd3,
        CMD_SET_FRONT  = 4'd4,
        CMD_SET_BACK   = 4'd5,
        CMD_PEEK_FRONT = 4'd6,
        CMD_PEEK_BACK  = 4'd7,
        CMD_CLEAR      = 4'd8,
        CMD_READ_POS   = 4'd9
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_data wdata;
        logic  re;
        t_idx  raddr;
    } t_mem_req;

    typedef struct packed {
        logic    use_mem;
        t_cnt    count;
        t_status status;
    } t_meta;

    function automatic t_idx ring_next(input t_idx i);
        t_idx r;
        if (i == t_idx'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = i + t_idx'(1);
        end
        return r;
    endfunction

    function automatic t_idx ring_prev(input t_idx i);
        t_idx r;
        if (i == '0) begin
            r = t_idx'(DEPTH - 1);
        end else begin
            r = i - t_idx'(1);
        end
        return r;
    endfunction

endpackage

// ----- sv/bdq_ram.sv -----
// Ring store of the queue with one write port and one registered read port.
module bdq_ram (
    input  logic              i_clk,
    input  bdq_pkg::t_mem_req i_req,
    output bdq_pkg::t_data    o_q
);

    bdq_pkg::t_data r_mem [bdq_pkg::DEPTH];
    bdq_pkg::t_data r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_q <= r_mem[i_req.raddr];
        end
    end

    assign o_q = r_q;

endmodule

// ----- sv/bdq_ctrl.sv -----
// Head, tail and count registers with the command decode that drives the ring store.
module bdq_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [bdq_pkg::CMD_W-1:0]   i_cmd,
    input  logic [bdq_pkg::VAL_W-1:0]   i_item_value,
    input  logic [bdq_pkg::POS_W-1:0]   i_position,
    output bdq_pkg::t_mem_req           o_req,
    output bdq_pkg::t_meta              o_meta
);

    localparam int CMP_W = (bdq_pkg::CNT_W > bdq_pkg::POS_W) ?
                           bdq_pkg::CNT_W : bdq_pkg::POS_W;

    bdq_pkg::t_idx   r_head, n_head;
    bdq_pkg::t_idx   r_tail, n_tail;
    bdq_pkg::t_cnt   r_count, n_count;
    bdq_pkg::t_data  val;
    bdq_pkg::t_idx   pos_addr;
    bdq_pkg::t_status status;
    logic [bdq_pkg::IDX_W:0]     pos_sum;
    logic [bdq_pkg::POS_W-1:0]   pos_m1;
    logic                        pos_ok;
    logic                        is_zero;
    logic                        is_full;
    logic                        we, re, use_mem;
    bdq_pkg::t_idx               waddr, raddr;

    assign val     = bdq_pkg::t_data'(i_item_value);
    assign is_zero = (r_count == '0);
    assign is_full = (r_count == bdq_pkg::t_cnt'(bdq_pkg::DEPTH));
    assign pos_ok  = (i_position != '0) &&
                     (CMP_W'(i_position) <= CMP_W'(r_count));
    assign pos_m1  = i_position - bdq_pkg::POS_W'(1);
    assign pos_sum = (bdq_pkg::IDX_W+1)'(r_head) + (bdq_pkg::IDX_W+1)'(pos_m1);

    always_comb begin
        if (pos_sum >= (bdq_pkg::IDX_W+1)'(bdq_pkg::DEPTH)) begin
            pos_addr = bdq_pkg::t_idx'(pos_sum - (bdq_pkg::IDX_W+1)'(bdq_pkg::DEPTH));
        end else begin
            pos_addr = bdq_pkg::t_idx'(pos_sum);
        end
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        we      = 1'b0;
        re      = 1'b0;
        use_mem = 1'b0;
        waddr   = r_head;
        raddr   = r_head;
        status  = bdq_pkg::ST_OK;
        case (bdq_pkg::t_cmd'(i_cmd))
            bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
                if (is_full) begin
                    status = bdq_pkg::ST_FULL;
                end else if (is_zero) begin
                    n_tail  = r_head;
                    waddr   = r_head;
                    we      = 1'b1;
                    n_count = bdq_pkg::t_cnt'(1);
                end else if (bdq_pkg::t_cmd'(i_cmd) == bdq_pkg::CMD_PUSH_FRONT) begin
                    n_head  = bdq_pkg::ring_prev(r_head);
                    waddr   = bdq_pkg::ring_prev(r_head);
                    we      = 1'b1;
                    n_count = r_count + bdq_pkg::t_cnt'(1);
                end else begin
                    n_tail  = bdq_pkg::ring_next(r_tail);
                    waddr   = bdq_pkg::ring_next(r_tail);
                    we      = 1'b1;
                    n_count = r_count + bdq_pkg::t_cnt'(1);
                end
            end
            bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK: begin
                if (is_zero) begin
                    status = bdq_pkg::ST_EMPTY;
                end else begin
                    re      = 1'b1;
                    use_mem = 1'b1;
                    raddr   = (bdq_pkg::t_cmd'(i_cmd) == bdq_pkg::CMD_POP_FRONT) ?
                              r_head : r_tail;
                    n_count = r_count - bdq_pkg::t_cnt'(1);
                    if (r_count == bdq_pkg::t_cnt'(1)) begin
                        n_tail = r_head;
                    end else if (bdq_pkg::t_cmd'(i_cmd) == bdq_pkg::CMD_POP_FRONT) begin
                        n_head = bdq_pkg::ring_next(r_head);
                    end else begin
                        n_tail = bdq_pkg::ring_prev(r_tail);
                    end
                end
            end
            bdq_pkg::CMD_SET_FRONT, bdq_pkg::CMD_SET_BACK: begin
                if (is_zero) begin
                    status = bdq_pkg::ST_EMPTY;
                end else begin
                    we    = 1'b1;
                    waddr = (bdq_pkg::t_cmd'(i_cmd) == bdq_pkg::CMD_SET_FRONT) ?
                            r_head : r_tail;
                end
            end
            bdq_pkg::CMD_PEEK_FRONT, bdq_pkg::CMD_PEEK_BACK: begin
                if (is_zero) begin
                    status = bdq_pkg::ST_EMPTY;
                end else begin
                    re      = 1'b1;
                    use_mem = 1'b1;
                    raddr   = (bdq_pkg::t_cmd'(i_cmd) == bdq_pkg::CMD_PEEK_FRONT) ?
                              r_head : r_tail;
                end
            end
            bdq_pkg::CMD_CLEAR: begin
                n_head  = '0;
                n_tail  = '0;
                n_count = '0;
            end
            bdq_pkg::CMD_READ_POS: begin
                if (is_zero) begin
                    status = bdq_pkg::ST_EMPTY;
                end else begin
                    re      = 1'b1;
                    use_mem = 1'b1;
                    raddr   = pos_ok ? pos_addr : r_tail;
                end
            end
            default: begin
                status = bdq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_req.we     = we && i_accept;
    assign o_req.waddr  = waddr;
    assign o_req.wdata  = val;
    assign o_req.re     = re && i_accept;
    assign o_req.raddr  = raddr;
    assign o_meta.use_mem = use_mem;
    assign o_meta.count   = n_count;
    assign o_meta.status  = status;

    // The count never passes the depth of the store.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= bdq_pkg::DEPTH)
        else $error("entry count exceeds depth");

    // In a non-empty queue the back entry always sits count minus one places after the front entry.
    a_tail_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |->
        ((32'(r_head) + 32'(r_count) - 32'd1) % bdq_pkg::DEPTH == 32'(r_tail)))
        else $error("tail index out of step with head and count");

    // An empty queue keeps its tail on its head.
    a_empty_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_tail == r_head))
        else $error("empty queue with tail away from head");

endmodule

// ----- sv/bdq_out.sv -----
// Two-stage result pipeline: read-data alignment stage and output register.
module bdq_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  bdq_pkg::t_meta                i_meta,
    input  bdq_pkg::t_data                i_mem_q,
    input  logic                          i_stall,
    output logic                          o_in_stall,
    output logic                          o_valid,
    output logic [bdq_pkg::RD_W-1:0]      o_read_data,
    output logic [bdq_pkg::COUNT_W-1:0]   o_entry_count,
    output logic                          o_is_empty,
    output logic [1:0]                    o_status
);

    logic                          r_a_valid;
    bdq_pkg::t_meta                r_a_meta;
    logic                          r_b_valid;
    logic [bdq_pkg::RD_W-1:0]      r_b_data;
    bdq_pkg::t_cnt                 r_b_count;
    bdq_pkg::t_status              r_b_status;
    logic                          a_move;

    assign a_move     = r_a_valid && (!r_b_valid || !i_stall);
    assign o_in_stall = r_a_valid && !a_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_accept) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_meta <= i_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_move) begin
            r_b_valid <= 1'b1;
        end else if (!i_stall) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_data   <= r_a_meta.use_mem ? bdq_pkg::RD_W'(i_mem_q) : '0;
            r_b_count  <= r_a_meta.count;
            r_b_status <= r_a_meta.status;
        end
    end

    assign o_valid       = r_b_valid;
    assign o_read_data   = r_b_data;
    assign o_entry_count = bdq_pkg::COUNT_W'(r_b_count);
    assign o_is_empty    = (r_b_count == '0);
    assign o_status      = r_b_status;

endmodule

// ----- sv/bounded_double_ended_queue.sv -----
// Top level of the bounded double-ended queue held in a ring store.
// Commands arrive on the input channel (i_valid, o_stall) as one word of
// i_cmd, i_item_value and i_position; a word is taken at a clock edge where
// i_valid is high and o_stall is low. Every command gives exactly one result
// word on the output channel (o_valid, i_stall) carrying o_read_data,
// o_entry_count, o_is_empty and o_status, in command order.
// The head, tail and count registers update at the edge that takes the
// command, and the ring store is written or read at that same edge.
// The result passes through the alignment register and the output register
// before it is presented. One command is taken every cycle while o_stall is low.
// The result path holds two words, the store's registered read and the
// output register, so a new command is still taken while one result waits.
// When the receiver keeps i_stall high with both words held, o_stall rises
// and the held result stays unchanged on the outputs.
// Reset empties the queue and the result path at once; the store itself is
// not cleared and needs no sweep, since only held entries are ever read.
module bounded_double_ended_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bdq_pkg::CMD_W-1:0]     i_cmd,
    input  logic [bdq_pkg::VAL_W-1:0]     i_item_value,
    input  logic [bdq_pkg::POS_W-1:0]     i_position,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bdq_pkg::RD_W-1:0]      o_read_data,
    output logic [bdq_pkg::COUNT_W-1:0]   o_entry_count,
    output logic                          o_is_empty,
    output logic [1:0]                    o_status
);

    logic              accept;
    logic              in_stall;
    bdq_pkg::t_mem_req req;
    bdq_pkg::t_meta    meta;
    bdq_pkg::t_data    mem_q;

    assign accept  = i_valid && !in_stall;
    assign o_stall = in_stall;

    bdq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_cmd        (i_cmd),
        .i_item_value (i_item_value),
        .i_position   (i_position),
        .o_req        (req),
        .o_meta       (meta)
    );

    bdq_ram u_ram (
        .i_clk (i_clk),
        .i_req (req),
        .o_q   (mem_q)
    );

    bdq_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_meta        (meta),
        .i_mem_q       (mem_q),
        .i_stall       (i_stall),
        .o_in_stall    (in_stall),
        .o_valid       (o_valid),
        .o_read_data   (o_read_data),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_status      (o_status)
    );

endmodule
